// ----- rtl/xpt_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xpt_pkg
// Shared types and constants of the two-level page translation block.
// ----------------------------------------------------------------------------
package xpt_pkg;

   // channel and register port widths
   localparam int CMD_W      = 2;
   localparam int ADDR_W     = 32;
   localparam int KIND_W     = 2;
   localparam int PFN_W      = 20;
   localparam int PAGE_SHIFT = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;

   // item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_TRANSLATE = 2'd0,
      CMD_READ_DATA = 2'd1,
      CMD_FLUSH     = 2'd2
   } cmd_type;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_PHYS = 2'd0,
      KIND_READ = 2'd1,
      KIND_BUSY = 2'd2
   } kind_type;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PMODE_ON       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGING_ENABLE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PAGE_DIR_BASE  = 2'd2;

   // configuration seen by the walker
   typedef struct packed {
      logic             pmode_on;
      logic             paging_enable;
      logic [PFN_W-1:0] page_dir_base;
   } cfg_type;

   // result produced by one item
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [ADDR_W-1:0] address;
   } res_type;

   // cache fill request from the walker
   typedef struct packed {
      logic             en;
      logic [PFN_W-1:0] vpn;
      logic [PFN_W-1:0] frame;
   } fill_type;

endpackage
`default_nettype wire

// ----- rtl/xpt_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xpt_req_if / xpt_rsp_if
// Valid/ready channels carrying request items and result items.
// ----------------------------------------------------------------------------
interface xpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [31:0] linear_address;
   logic [31:0] read_data;

   modport source (output valid, command, linear_address, read_data, input ready);
   modport sink   (input valid, command, linear_address, read_data, output ready);
endinterface

interface xpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] address;

   modport source (output valid, kind, address, input ready);
   modport sink   (input valid, kind, address, output ready);
endinterface
`default_nettype wire

// ----- rtl/xpt_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xpt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module xpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic                                 rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- rtl/xpt_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xpt_walk
// Cache hit check, walk sequencing, valid bits and result forming for one
// item taken from the input register.
// ----------------------------------------------------------------------------
module xpt_walk import xpt_pkg::*; #(
   parameter int INDEX_BITS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [CMD_W-1:0]      command,
   input  wire logic [ADDR_W-1:0]     linear_address,
   input  wire logic [ADDR_W-1:0]     read_data,
   input  wire cfg_type               cfg,
   input  wire logic [((PFN_W - INDEX_BITS) > 0 ? (PFN_W - INDEX_BITS) : 1)-1:0] entry_tag,
   input  wire logic [PFN_W-1:0]      entry_frame,
   output res_type                    res,
   output fill_type                   fill
);

   localparam int DEPTH = 1 << INDEX_BITS;
   localparam int IDX_W = (INDEX_BITS > 0) ? INDEX_BITS : 1;
   localparam int TAG_W = ((PFN_W - INDEX_BITS) > 0) ? (PFN_W - INDEX_BITS) : 1;
   localparam logic [PFN_W-1:0] IDX_MASK = PFN_W'((1 << INDEX_BITS) - 1);

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_DIR  = 2'd1,
      PH_PTE  = 2'd2
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] pending_ff, pending_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;

   logic [PFN_W-1:0]  vpn;
   logic [IDX_W-1:0]  idx;
   logic [TAG_W-1:0]  tag;
   logic              hit;

   // lookup fields of the incoming address
   assign vpn = linear_address[ADDR_W-1:PAGE_SHIFT];
   assign idx = IDX_W'(vpn & IDX_MASK);
   assign tag = TAG_W'(vpn >> INDEX_BITS);
   assign hit = valid_ff[idx] && (entry_tag == tag);

   // per-item decision
   always_comb begin
      phase_in    = phase_ff;
      pending_in  = pending_ff;
      valid_in    = valid_ff;
      res.valid   = 1'b0;
      res.kind    = KIND_PHYS;
      res.address = '0;
      fill.en     = 1'b0;
      fill.vpn    = pending_ff[ADDR_W-1:PAGE_SHIFT];
      fill.frame  = read_data[ADDR_W-1:PAGE_SHIFT];
      case (cmd_type'(command))
         CMD_TRANSLATE: begin
            res.valid = 1'b1;
            if (phase_ff != PH_IDLE) begin
               res.kind = KIND_BUSY;
            end else if (!cfg.pmode_on || !cfg.paging_enable) begin
               res.address = linear_address;
            end else if (hit) begin
               res.address = {entry_frame, linear_address[PAGE_SHIFT-1:0]};
            end else begin
               res.kind    = KIND_READ;
               res.address = {cfg.page_dir_base, linear_address[31:22], 2'b00};
               pending_in  = linear_address;
               phase_in    = PH_DIR;
            end
         end
         CMD_READ_DATA: begin
            case (phase_ff)
               PH_DIR: begin
                  res.valid   = 1'b1;
                  res.kind    = KIND_READ;
                  res.address = {read_data[31:12], pending_ff[21:12], 2'b00};
                  phase_in    = PH_PTE;
               end
               PH_PTE: begin
                  res.valid   = 1'b1;
                  res.address = {read_data[31:12], pending_ff[11:0]};
                  fill.en     = 1'b1;
                  valid_in[IDX_W'(fill.vpn & IDX_MASK)] = 1'b1;
                  phase_in    = PH_IDLE;
               end
               default: begin
                  // stray read data, no result
               end
            endcase
         end
         CMD_FLUSH: begin
            valid_in = '0;
         end
         default: begin
            // unused code, no result
         end
      endcase
      if (!advance) begin
         res.valid = 1'b0;
         fill.en   = 1'b0;
      end
   end

   // walk state and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         pending_ff <= '0;
         valid_ff   <= '0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/x86_two_level_page_translate.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// x86_two_level_page_translate
// Two-level page translation with a direct-mapped translation cache.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result register is stalled: an item is
// captured in the input register while the cache RAM is read at its page
// index, and once the result register is free the hit check, walk step and
// result land in it. The cache RAM read is registered; a fill written in the
// same cycle as the read is forwarded. Cache misses are answered with a
// directory read request, then a table read request, each fed back as
// read-data items; a translate item during a walk is answered busy. Flush
// and reset each clear every valid bit, so no clearing pass follows reset.
// Registers are to be written only while the block is idle (it has no check).
// ----------------------------------------------------------------------------
module x86_two_level_page_translate import xpt_pkg::*; #(
   parameter int INDEX_BITS = 6
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   xpt_req_if.sink                    req,
   xpt_rsp_if.source                  rsp,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH    = 1 << INDEX_BITS;
   localparam int IDX_W    = (INDEX_BITS > 0) ? INDEX_BITS : 1;
   localparam int TAG_W    = ((PFN_W - INDEX_BITS) > 0) ? (PFN_W - INDEX_BITS) : 1;
   localparam int ENTRY_W  = TAG_W + PFN_W;
   localparam logic [PFN_W-1:0] IDX_MASK = PFN_W'((1 << INDEX_BITS) - 1);

   cfg_type           cfg_ff;
   logic              s1_valid_ff;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [ADDR_W-1:0] s1_la_ff;
   logic [ADDR_W-1:0] s1_rd_ff;
   logic              byp_ff, byp_in;
   logic [ENTRY_W-1:0] byp_data_ff;
   logic              rsp_valid_ff;
   kind_type          rsp_kind_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;

   logic              accept;
   logic              out_free;
   logic              advance;
   logic [IDX_W-1:0]  req_idx;
   logic [IDX_W-1:0]  fill_idx;
   logic [ENTRY_W-1:0] fill_entry;
   logic [ENTRY_W-1:0] ram_entry;
   logic [ENTRY_W-1:0] entry;
   res_type           res;
   fill_type          fill;

   // handshake and pipeline movement
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign advance   = s1_valid_ff && out_free;
   assign req.ready = !reset && (!s1_valid_ff || out_free);
   assign accept    = req.valid && req.ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PMODE_ON:       cfg_ff.pmode_on       <= csr_wdata[0];
            CSR_PAGING_ENABLE:  cfg_ff.paging_enable  <= csr_wdata[0];
            CSR_PAGE_DIR_BASE:  cfg_ff.page_dir_base  <= csr_wdata;
            default: begin
               // no register at this index
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff <= req.command;
         s1_la_ff  <= req.linear_address;
         s1_rd_ff  <= req.read_data;
      end
   end

   // cache RAM, read at acceptance, written by walk fills
   assign req_idx    = IDX_W'(req.linear_address[ADDR_W-1:PAGE_SHIFT] & IDX_MASK);
   assign fill_idx   = IDX_W'(fill.vpn & IDX_MASK);
   assign fill_entry = {TAG_W'(fill.vpn >> INDEX_BITS), fill.frame};

   xpt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_cache (
      .clock   (clock),
      .wr_en   (fill.en),
      .wr_addr (fill_idx),
      .wr_data (fill_entry),
      .rd_en   (accept),
      .rd_addr (req_idx),
      .rd_data (ram_entry)
   );

   // forward a fill that lands on the entry being read
   assign byp_in = fill.en && (fill_idx == req_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (accept) begin
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_data_ff <= fill_entry;
      end
   end

   assign entry = byp_ff ? byp_data_ff : ram_entry;

   // walk and result logic
   xpt_walk #(
      .INDEX_BITS (INDEX_BITS)
   ) u_walk (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .command        (s1_cmd_ff),
      .linear_address (s1_la_ff),
      .read_data      (s1_rd_ff),
      .cfg            (cfg_ff),
      .entry_tag      (entry[ENTRY_W-1:PFN_W]),
      .entry_frame    (entry[PFN_W-1:0]),
      .res            (res),
      .fill           (fill)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res.valid) begin
         rsp_kind_ff <= res.kind;
         rsp_addr_ff <= res.address;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.kind    = rsp_kind_ff;
   assign rsp.address = rsp_addr_ff;

endmodule
`default_nettype wire

// ----- rtl/xpt_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// xpt_checker
// Port-level checks of the page translation block, bound to the top level.
// ----------------------------------------------------------------------------
module xpt_checker import xpt_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [ADDR_W-1:0] rsp_address
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result stems from an earlier accepted item
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result without a matching accepted item");

   // busy answers carry a zero address
   a_busy_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_BUSY) |-> rsp_address == '0)
      else $error("busy result with non-zero address");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_address)
                                     && $stable(rsp_kind)))
      else $error("stalled result changed");

endmodule

bind x86_two_level_page_translate xpt_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_kind    (rsp.kind),
   .rsp_address (rsp.address)
);
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-level page translation block.
// ----------------------------------------------------------------------------
// Items go in through a queue-fed driver, and the results are checked by a
// monitor against a cycle-free predictor of the page walker and its cache.
// A directed opening covers bypass, hit, miss, busy, flush during a walk,
// stray read data and the unused command. Random walks over a small set of
// hot pages then run under several register settings and idling patterns,
// including one long result stall that backs up the input side.
// ----------------------------------------------------------------------------
module tb_top;
   import xpt_pkg::*;

   localparam int IDX_BITS   = 6;
   localparam int DEPTH      = 1 << IDX_BITS;
   localparam int TAG_W      = PFN_W - IDX_BITS;
   localparam int LONG_HOLD  = 64;
   localparam int IDLE_LIMIT = 4000;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum logic [1:0] {
      WALK_IDLE,
      WALK_DIR,
      WALK_PTE
   } walk_state_type;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [ADDR_W-1:0] lin;
      logic [ADDR_W-1:0] rdata;
   } req_item_type;

   typedef struct {
      kind_type          kind;
      logic [ADDR_W-1:0] address;
   } xlat_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   xpt_req_if req_ch ();
   xpt_rsp_if rsp_ch ();

   x86_two_level_page_translate #(
      .INDEX_BITS (IDX_BITS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // stimulus and expected results
   req_item_type    item_q[$];
   xlat_result_type awaited_q[$];

   // predictor copy of the walker, the cache and the registers
   logic              tlb_valid [DEPTH];
   logic [TAG_W-1:0]  tlb_tag   [DEPTH];
   logic [PFN_W-1:0]  tlb_frame [DEPTH];
   walk_state_type    walk_state = WALK_IDLE;
   logic [ADDR_W-1:0] walk_lin = '0;
   logic              cfg_protect = 1'b0;
   logic              cfg_paging = 1'b0;
   logic [PFN_W-1:0]  cfg_dir_base = '0;

   // handshake flags, set at the rising edge and read at the falling edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   int send_idle_pct = 9;
   int recv_idle_pct = 68;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   int queued_total = 0;
   int accepted_total = 0;
   int err_count = 0;
   int n_bypass = 0;
   int n_hits = 0;
   int n_walks = 0;
   int n_busy = 0;
   int n_flush = 0;
   int n_results = 0;

   logic [PFN_W-1:0] hot_vpn [12];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
   endtask

   task automatic add_result(input kind_type kind, input logic [ADDR_W-1:0] address);
      xlat_result_type r;
      r.kind = kind;
      r.address = address;
      awaited_q.push_back(r);
   endtask

   // advance the predictor by one accepted item
   task automatic walk_predict(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] lin,
                               input logic [ADDR_W-1:0] rdata);
      logic [PFN_W-1:0]    vpn;
      logic [IDX_BITS-1:0] idx;
      logic [TAG_W-1:0]    tag;
      vpn = lin[ADDR_W-1:PAGE_SHIFT];
      idx = vpn[IDX_BITS-1:0];
      tag = vpn[PFN_W-1:IDX_BITS];
      case (cmd)
         CMD_TRANSLATE: begin
            if (walk_state != WALK_IDLE) begin
               add_result(KIND_BUSY, '0);
               n_busy++;
            end else if (!cfg_protect || !cfg_paging) begin
               add_result(KIND_PHYS, lin);
               n_bypass++;
            end else if (tlb_valid[idx] && tlb_tag[idx] == tag) begin
               add_result(KIND_PHYS, {tlb_frame[idx], lin[PAGE_SHIFT-1:0]});
               n_hits++;
            end else begin
               // miss: ask for the directory entry
               walk_lin = lin;
               walk_state = WALK_DIR;
               add_result(KIND_READ, {cfg_dir_base, lin[31:22], 2'b00});
            end
         end
         CMD_READ_DATA: begin
            if (walk_state == WALK_DIR) begin
               walk_state = WALK_PTE;
               add_result(KIND_READ, {rdata[31:12], walk_lin[21:12], 2'b00});
            end else if (walk_state == WALK_PTE) begin
               // table entry back: fill the one cache entry
               vpn = walk_lin[ADDR_W-1:PAGE_SHIFT];
               idx = vpn[IDX_BITS-1:0];
               tlb_valid[idx] = 1'b1;
               tlb_tag[idx] = vpn[PFN_W-1:IDX_BITS];
               tlb_frame[idx] = rdata[31:12];
               walk_state = WALK_IDLE;
               add_result(KIND_PHYS, {rdata[31:12], walk_lin[PAGE_SHIFT-1:0]});
               n_walks++;
            end
         end
         CMD_FLUSH: begin
            foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
            n_flush++;
         end
         default: begin
         end
      endcase
   endtask

   // monitor: check results, feed the predictor, track register writes
   always @(posedge clock) begin : monitor
      xlat_result_type want;
      req_fire = req_ch.valid && req_ch.ready;
      rsp_fire = rsp_ch.valid && rsp_ch.ready;
      if (!reset) begin
         if (rsp_fire) begin
            n_results++;
            if (awaited_q.size() == 0) begin
               report_mismatch($sformatf("unexpected item kind %0d address %h",
                                         rsp_ch.kind, rsp_ch.address));
            end else begin
               want = awaited_q.pop_front();
               if (rsp_ch.kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, wanted %0d",
                                            rsp_ch.kind, want.kind));
               if (rsp_ch.address !== want.address)
                  report_mismatch($sformatf("address %h, wanted %h",
                                            rsp_ch.address, want.address));
            end
         end
         if (req_fire) begin
            accepted_total++;
            walk_predict(req_ch.command, req_ch.linear_address, req_ch.read_data);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_PMODE_ON:       cfg_protect = csr_wdata[0];
               CSR_PAGING_ENABLE:  cfg_paging = csr_wdata[0];
               CSR_PAGE_DIR_BASE:  cfg_dir_base = csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // driver: offer queued items, with random gaps
   always @(negedge clock) begin : driver
      req_item_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = item_q.pop_front();
            req_ch.command <= nxt.cmd;
            req_ch.linear_address <= nxt.lin;
            req_ch.read_data <= nxt.rdata;
            req_ch.valid <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus one long hold when asked
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = LONG_HOLD - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog: cycles with nothing accepted on either side
   always @(negedge clock) begin : watchdog
      if (!reset) begin
         if (req_fire || rsp_fire) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] lin,
                            input logic [ADDR_W-1:0] rdata);
      req_item_type it;
      it.cmd = cmd;
      it.lin = lin;
      it.rdata = rdata;
      item_q.push_back(it);
      queued_total++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_total != queued_total || awaited_q.size() != 0);
      // a trailing item with no result may still be in the pipe
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // enables carry random upper bits, only bit 0 counts
   task automatic set_mode(input logic prot, input logic pag, input logic [PFN_W-1:0] base);
      logic [31:0] r;
      r = $urandom;
      write_reg(CSR_PMODE_ON, {r[19:1], prot});
      r = $urandom;
      write_reg(CSR_PAGING_ENABLE, {r[19:1], pag});
      write_reg(CSR_PAGE_DIR_BASE, base);
   endtask

   function automatic logic [ADDR_W-1:0] pick_linear();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(99) < 70) return {hot_vpn[$urandom_range(11)], r[11:0]};
      return r;
   endfunction

   // random walks with content, plus flushes, strays and broken walks
   task automatic queue_walk_mix(input int n);
      int start;
      int r;
      start = queued_total;
      while (queued_total - start < n) begin
         r = $urandom_range(99);
         if (r < 4) begin
            push_item(CMD_FLUSH, $urandom, $urandom);
         end else if (r < 6) begin
            push_item(CMD_UNUSED, $urandom, $urandom);
         end else if (r < 9) begin
            push_item(CMD_READ_DATA, $urandom, $urandom);
         end else begin
            push_item(CMD_TRANSLATE, pick_linear(), $urandom);
            if ($urandom_range(99) < 6) push_item(CMD_TRANSLATE, pick_linear(), $urandom);
            push_item(CMD_READ_DATA, $urandom, $urandom);
            if ($urandom_range(99) < 5) push_item(CMD_FLUSH, $urandom, $urandom);
            if ($urandom_range(99) >= 4) push_item(CMD_READ_DATA, $urandom, $urandom);
         end
      end
   endtask

   initial begin : main
      logic [31:0] r;
      logic [IDX_BITS-1:0] hot_idx [4];
      foreach (tlb_valid[i]) tlb_valid[i] = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.command = CMD_TRANSLATE;
      req_ch.linear_address = '0;
      req_ch.read_data = '0;
      rsp_ch.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_PMODE_ON;
      csr_wdata = '0;
      reset = 1'b1;

      // hot pages share four cache indexes, the two end ones among them
      hot_idx[0] = '0;
      hot_idx[1] = '1;
      hot_idx[2] = 6'd21;
      hot_idx[3] = 6'd42;
      foreach (hot_vpn[i]) begin
         r = $urandom;
         hot_vpn[i] = {r[TAG_W-1:0], hot_idx[i % 4]};
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset settings pass addresses through
      push_item(CMD_TRANSLATE, 32'h0000_0000, $urandom);
      push_item(CMD_TRANSLATE, 32'hffff_ffff, 32'hffff_ffff);
      push_item(CMD_READ_DATA, 32'h0000_0000, 32'hffff_ffff);
      push_item(CMD_FLUSH, 32'h0000_0000, 32'h0000_0000);
      push_item(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
      wait_drained();
      set_mode(1'b1, 1'b1, '1);

      // directed: miss, busy, flush during a walk, hit, eviction
      push_item(CMD_TRANSLATE, 32'hffff_ffff, 32'h0);
      push_item(CMD_TRANSLATE, 32'h1234_5678, 32'h0);
      push_item(CMD_READ_DATA, 32'h0, 32'hffff_ffff);
      push_item(CMD_FLUSH, 32'h0, 32'h0);
      push_item(CMD_READ_DATA, 32'h0, 32'h0000_0000);
      push_item(CMD_TRANSLATE, 32'hffff_ffff, 32'h0);
      push_item(CMD_TRANSLATE, 32'hffff_f123, 32'h0);
      push_item(CMD_TRANSLATE, 32'h0003_f000, 32'h0);
      push_item(CMD_READ_DATA, 32'h0, 32'h0000_0fff);
      push_item(CMD_READ_DATA, 32'h0, 32'hffff_f000);
      push_item(CMD_TRANSLATE, 32'hffff_ffff, 32'h0);
      push_item(CMD_READ_DATA, 32'h0, 32'h5a5a_5a5a);
      push_item(CMD_READ_DATA, 32'h0, 32'ha5a5_a5a5);
      push_item(CMD_FLUSH, 32'hffff_ffff, 32'hffff_ffff);
      push_item(CMD_TRANSLATE, 32'hffff_ffff, 32'h0);
      push_item(CMD_TRANSLATE, 32'h0000_0000, 32'h0);
      push_item(CMD_READ_DATA, 32'h0, 32'h0000_0000);
      push_item(CMD_READ_DATA, 32'h0, 32'h8000_0000);
      push_item(CMD_UNUSED, 32'h0, 32'h0);
      push_item(CMD_READ_DATA, 32'h0, 32'h0);
      queue_walk_mix(250);
      wait_drained();

      // sender mostly idle, receiver mostly ready, directory at frame zero
      send_idle_pct = 68;
      recv_idle_pct = 9;
      set_mode(1'b1, 1'b1, '0);
      queue_walk_mix(200);
      wait_drained();

      // no idling, one long result stall
      send_idle_pct = 0;
      recv_idle_pct = 0;
      r = $urandom;
      set_mode(1'b1, 1'b1, r[PFN_W-1:0]);
      queue_walk_mix(150);
      hold_token++;
      wait_drained();

      // each enable off on its own
      set_mode(1'b0, 1'b1, '1);
      queue_walk_mix(40);
      wait_drained();
      r = $urandom;
      set_mode(1'b1, 1'b0, r[PFN_W-1:0]);
      queue_walk_mix(40);
      wait_drained();
      repeat (8) @(negedge clock);

      while (awaited_q.size() != 0) begin
         report_mismatch($sformatf("result of kind %0d never came", awaited_q[0].kind));
         void'(awaited_q.pop_front());
      end

      $display("covered %0d items, %0d results: %0d passed through, %0d cache hits,",
               accepted_total, n_results, n_bypass, n_hits);
      $display("  %0d walks filled, %0d busy rejects, %0d flushes, %0d mismatches",
               n_walks, n_busy, n_flush, err_count);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
